// File: rtl/didbt_pkg.sv
// ----------------------------------------------------------------------------
// didbt_pkg: shared types and constants
// Widths, operation/mode/action codes and the queue entry format for the
// display idle dim/blank timer.
// ----------------------------------------------------------------------------
package didbt_pkg;

	localparam int LVL_W      = 12;
	localparam int TO_W       = 16;
	localparam int IDLE_W     = 17;
	localparam int ACT_W      = 3;
	localparam int OP_W       = 2;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_BEATS  = 4;
	localparam int BEAT_IDX_W = 2;
	localparam int BEAT_CNT_W = 3;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_WAKE   = 2'd1;
	localparam logic [OP_W-1:0] OP_BLANK  = 2'd2;
	localparam logic [OP_W-1:0] OP_TOGGLE = 2'd3;

	localparam logic [MODE_W-1:0] MODE_ON      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DIM     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BLANKED = 2'd3;

	localparam logic [ACT_W-1:0] ACT_STATUS        = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SET_LEVEL     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_BLANK_HOOK    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UNBLANK_HOOK  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PANEL_BLANK   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PANEL_UNBLANK = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK_EN = 2'd1;

	localparam logic [LVL_W-1:0]  DIM_LEVEL = 12'd5;
	localparam logic [LVL_W-1:0]  OFF_LEVEL = 12'd0;
	localparam logic [TO_W-1:0]   DIM_LEAD  = 16'd2;
	localparam logic [IDLE_W-1:0] IDLE_MAX  = 17'h1FFFF;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [LVL_W-1:0] level_t;

	typedef struct packed {
		action_t [MAX_BEATS-1:0] act;
		level_t  [MAX_BEATS-1:0] lvl;
		logic    [BEAT_IDX_W-1:0] last_idx;
		logic                     off;
	} entry_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [TO_W-1:0]      data;
	} cfg_wr_t;

endpackage

// File: rtl/didbt_front.sv
// ----------------------------------------------------------------------------
// didbt_front: item decode and mode state
// Holds the config registers and the mode, idle counter and saved level.
// Turns each accepted item into one entry listing its ordered actions.
// ----------------------------------------------------------------------------
module didbt_front
	import didbt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_wr_t          cfg,
	input  logic             accept,
	input  logic [OP_W-1:0]  operation,
	input  level_t           live_level,
	input  logic             level_known,
	output entry_t           ent
);

	logic [TO_W-1:0]   timeout_q;
	logic              blank_en_q;
	logic [MODE_W-1:0] mode_q;
	logic [IDLE_W-1:0] idle_q;
	level_t            saved_level_q;
	logic              saved_known_q;

	logic [MODE_W-1:0]     m;
	logic [IDLE_W-1:0]     idle_inc;
	logic [IDLE_W-1:0]     idle_n;
	level_t                sv_lvl;
	logic                  sv_known;
	logic [BEAT_CNT_W-1:0] n;
	logic [BEAT_CNT_W-1:0] n_m1;
	logic                  is_wake;
	logic                  is_blank;
	logic                  dim_hit;
	logic                  off_hit;

	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign is_wake  = (operation == OP_WAKE) || (operation == OP_TOGGLE && mode_q[1]);
	assign is_blank = (operation == OP_BLANK) || (operation == OP_TOGGLE && !mode_q[1]);
	assign dim_hit  = (timeout_q > DIM_LEAD) && (idle_inc > {1'b0, timeout_q - DIM_LEAD})
		&& (mode_q == MODE_ON);

	always_comb begin
		ent      = '0;
		n        = '0;
		m        = mode_q;
		idle_n   = idle_q;
		sv_lvl   = saved_level_q;
		sv_known = saved_known_q;
		off_hit  = 1'b0;
		if (operation == OP_TICK) begin
			idle_n = idle_inc;
			if (dim_hit) begin
				sv_lvl   = live_level;
				sv_known = level_known;
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_SET_LEVEL;
				ent.lvl[n[BEAT_IDX_W-1:0]] = DIM_LEVEL;
				n = n + 1'b1;
				m = MODE_DIM;
			end
			off_hit = (timeout_q != '0) && (idle_inc > {1'b0, timeout_q})
				&& (m inside {MODE_ON, MODE_DIM});
			if (off_hit) begin
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_SET_LEVEL;
				ent.lvl[n[BEAT_IDX_W-1:0]] = OFF_LEVEL;
				n = n + 1'b1;
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_BLANK_HOOK;
				n = n + 1'b1;
				m = MODE_OFF;
				if (blank_en_q) begin
					ent.act[n[BEAT_IDX_W-1:0]] = ACT_PANEL_BLANK;
					n = n + 1'b1;
					m = MODE_BLANKED;
				end
			end
		end else if (is_wake) begin
			idle_n = '0;
			if (mode_q == MODE_BLANKED) begin
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_PANEL_UNBLANK;
				n = n + 1'b1;
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_UNBLANK_HOOK;
				n = n + 1'b1;
			end
			if (mode_q != MODE_ON && saved_known_q) begin
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_SET_LEVEL;
				ent.lvl[n[BEAT_IDX_W-1:0]] = saved_level_q;
				n = n + 1'b1;
			end
			m = MODE_ON;
		end else if (is_blank) begin
			if (m inside {MODE_ON, MODE_DIM}) begin
				sv_lvl   = live_level;
				sv_known = level_known;
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_SET_LEVEL;
				ent.lvl[n[BEAT_IDX_W-1:0]] = OFF_LEVEL;
				n = n + 1'b1;
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_BLANK_HOOK;
				n = n + 1'b1;
				m = MODE_OFF;
			end
			if (m == MODE_OFF && blank_en_q) begin
				ent.act[n[BEAT_IDX_W-1:0]] = ACT_PANEL_BLANK;
				n = n + 1'b1;
				m = MODE_BLANKED;
			end
		end
		if (n == '0) begin
			ent.act[0] = ACT_STATUS;
			n = n + 1'b1;
		end
		n_m1         = n - 1'b1;
		ent.last_idx = n_m1[BEAT_IDX_W-1:0];
		ent.off      = m[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= '0;
			blank_en_q    <= 1'b1;
			mode_q        <= MODE_ON;
			idle_q        <= '0;
			saved_level_q <= '0;
			saved_known_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q        <= m;
				idle_q        <= idle_n;
				saved_level_q <= sv_lvl;
				saved_known_q <= sv_known;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TIMEOUT: begin
						timeout_q <= cfg.data;
						idle_q    <= '0;
					end
					CFG_BLANK_EN: begin
						blank_en_q <= cfg.data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/didbt_queue.sv
// ----------------------------------------------------------------------------
// didbt_queue: entry queue
// Small FIFO of action entries between the decode front and the beat
// serializer.
// ----------------------------------------------------------------------------
module didbt_queue
	import didbt_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t pop_data,
	output logic   full,
	output logic   empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/didbt_back.sv
// ----------------------------------------------------------------------------
// didbt_back: beat serializer
// Takes one entry at a time from the queue and sends its actions as output
// beats, in order, flagging the final one.
// ----------------------------------------------------------------------------
module didbt_back
	import didbt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  entry_t  q_data,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_stall,
	output action_t action,
	output level_t  level,
	output logic    screen_off,
	output logic    last
);

	entry_t                ent_q;
	logic [BEAT_IDX_W-1:0] idx_q;
	logic                  busy_q;
	logic                  fire;
	logic                  done;

	assign fire  = busy_q && !out_stall;
	assign done  = fire && (idx_q == ent_q.last_idx);
	assign q_pop = !q_empty && (!busy_q || done);

	assign out_valid  = busy_q;
	assign action     = ent_q.act[idx_q];
	assign level      = ent_q.lvl[idx_q];
	assign screen_off = ent_q.off;
	assign last       = (idx_q == ent_q.last_idx);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// File: rtl/display_idle_dim_blank_timer_top.sv
// ----------------------------------------------------------------------------
// display_idle_dim_blank_timer_top: screen idle dim/off/blank controller
// Decodes tick, wake, blank and toggle items into ordered display actions.
// ----------------------------------------------------------------------------
// Each accepted item yields one to four output beats (status only, or its
// ordered brightness, hook and panel actions); the last beat of an item has
// last set. The front decodes an item in the cycle it is accepted and can
// take one item per clock while the entry queue has room; the serializer
// sends one beat per clock while out_stall is low, so the sustained item
// rate drops as items cause more beats (at most 4). Each item is held in
// the queue, then the back entry register. Config writes are always ready.
// ----------------------------------------------------------------------------
module display_idle_dim_blank_timer_top
	import didbt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TO_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [LVL_W-1:0]     live_level,
	input  logic                 level_known,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ACT_W-1:0]     action,
	output logic [LVL_W-1:0]     level,
	output logic                 screen_off,
	output logic                 last
);

	cfg_wr_t cfg;
	entry_t  push_ent;
	entry_t  pop_ent;
	logic    accept;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	didbt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.operation   (operation),
		.live_level  (live_level),
		.level_known (level_known),
		.ent         (push_ent)
	);

	didbt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_ent),
		.pop       (q_pop),
		.pop_data  (pop_ent),
		.full      (q_full),
		.empty     (q_empty)
	);

	didbt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (pop_ent),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.level      (level),
		.screen_off (screen_off),
		.last       (last)
	);

	a_level_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_SET_LEVEL |-> level == '0)
		else $error("nonzero level on a beat that sets no brightness");

	a_item_beats_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && screen_off == $past(screen_off))
		else $error("item beats broken up or screen_off changed within an item");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !q_empty)
		else $error("accepted item did not reach the entry queue");

endmodule

// File: tb/sv/tb_display_idle_dim_blank_timer_top.sv
// ----------------------------------------------------------------------------
// tb_display_idle_dim_blank_timer_top: self-checking bench for the idle timer
// Queue-fed driver and clocked monitor around the screen idle controller.
// Each accepted item runs through a local predictor of the on/dim/off/blanked
// state machine, which queues the ordered actions that item should produce.
// Every output beat is compared field by field with the oldest of those.
// The run covers directed corner cases, randomized tick/wake/blank sequences
// under several register settings and idling schemes, and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_display_idle_dim_blank_timer_top;
	import didbt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 64;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [OP_W-1:0] op;
		level_t          live;
		logic            known;
	} item_t;

	typedef struct packed {
		action_t action;
		level_t  level;
		logic    off;
		logic    last;
	} beat_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [TO_W-1:0]      cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      operation   = '0;
	logic [LVL_W-1:0]     live_level  = '0;
	logic                 level_known = 1'b0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [ACT_W-1:0]     action;
	logic [LVL_W-1:0]     level;
	logic                 screen_off;
	logic                 last;

	item_t pending_items[$];
	beat_t expected_beats[$];
	item_t next_item;

	// predicted controller state
	logic [MODE_W-1:0] scr_mode;
	logic [IDLE_W-1:0] scr_idle;
	level_t            scr_saved_level;
	logic              scr_saved_known;
	logic [TO_W-1:0]   scr_timeout;
	logic              scr_blank_en;

	action_t step_act[MAX_BEATS];
	level_t  step_lvl[MAX_BEATS];
	int      step_n;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_armed    = 1'b0;
	logic hold_used     = 1'b0;
	int   hold_left     = 0;
	int   quiet         = 0;
	int   errors        = 0;
	int   items_sent    = 0;
	int   beats_seen    = 0;
	int   cfg_writes    = 0;
	int   action_count[8];

	display_idle_dim_blank_timer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.live_level (live_level),
		.level_known(level_known),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.level      (level),
		.screen_off (screen_off),
		.last       (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void add_action(action_t a, level_t l);
		step_act[step_n] = a;
		step_lvl[step_n] = l;
		step_n++;
	endfunction

	function automatic void go_dark();
		add_action(ACT_SET_LEVEL, OFF_LEVEL);
		add_action(ACT_BLANK_HOOK, '0);
		scr_mode = MODE_OFF;
	endfunction

	function automatic void wake_screen();
		scr_idle = '0;
		if (scr_mode == MODE_BLANKED) begin
			add_action(ACT_PANEL_UNBLANK, '0);
			add_action(ACT_UNBLANK_HOOK, '0);
		end
		if (scr_mode != MODE_ON && scr_saved_known)
			add_action(ACT_SET_LEVEL, scr_saved_level);
		scr_mode = MODE_ON;
	endfunction

	function automatic void blank_screen(level_t live, logic known);
		if (scr_mode == MODE_ON || scr_mode == MODE_DIM) begin
			scr_saved_level = live;
			scr_saved_known = known;
			go_dark();
		end
		if (scr_mode == MODE_OFF && scr_blank_en) begin
			add_action(ACT_PANEL_BLANK, '0);
			scr_mode = MODE_BLANKED;
		end
	endfunction

	function automatic void predict_actions(item_t it);
		int    idle_i;
		int    tmo_i;
		logic  off;
		beat_t b;
		step_n = 0;
		case (it.op)
			OP_TICK: begin
				if (scr_idle != IDLE_MAX)
					scr_idle = scr_idle + 1'b1;
				idle_i = int'(scr_idle);
				tmo_i  = int'(scr_timeout);
				if (tmo_i > int'(DIM_LEAD) && idle_i > tmo_i - int'(DIM_LEAD)
						&& scr_mode == MODE_ON) begin
					scr_saved_level = it.live;
					scr_saved_known = it.known;
					add_action(ACT_SET_LEVEL, DIM_LEVEL);
					scr_mode = MODE_DIM;
				end
				if (tmo_i > 0 && idle_i > tmo_i
						&& (scr_mode == MODE_ON || scr_mode == MODE_DIM)) begin
					go_dark();
					if (scr_blank_en) begin
						add_action(ACT_PANEL_BLANK, '0);
						scr_mode = MODE_BLANKED;
					end
				end
			end
			OP_WAKE:  wake_screen();
			OP_BLANK: blank_screen(it.live, it.known);
			OP_TOGGLE: begin
				if (scr_mode == MODE_OFF || scr_mode == MODE_BLANKED)
					wake_screen();
				else
					blank_screen(it.live, it.known);
			end
		endcase
		if (step_n == 0)
			add_action(ACT_STATUS, '0);
		off = (scr_mode == MODE_OFF || scr_mode == MODE_BLANKED);
		for (int k = 0; k < step_n; k++) begin
			b.action = step_act[k];
			b.level  = step_lvl[k];
			b.off    = off;
			b.last   = (k == step_n - 1);
			expected_beats.push_back(b);
		end
	endfunction

	function automatic void check_beat();
		beat_t want;
		beats_seen++;
		action_count[action]++;
		if (expected_beats.size() == 0) begin
			$error("unexpected beat: action %0d level %0d", action, level);
			errors++;
			return;
		end
		want = expected_beats.pop_front();
		if (action !== want.action) begin
			$error("action mismatch: expected %0d, got %0d", want.action, action);
			errors++;
		end
		if (level !== want.level) begin
			$error("level mismatch: expected %0d, got %0d", want.level, level);
			errors++;
		end
		if (screen_off !== want.off) begin
			$error("screen_off mismatch: expected %0d, got %0d", want.off, screen_off);
			errors++;
		end
		if (last !== want.last) begin
			$error("last mismatch: expected %0d, got %0d", want.last, last);
			errors++;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				predict_actions(item_t'{operation, live_level, level_known});
				items_sent++;
			end
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid    <= 1'b1;
				operation   <= next_item.op;
				live_level  <= next_item.live;
				level_known <= next_item.known;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_armed && !hold_used && out_valid) begin
				hold_used = 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [TO_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_TIMEOUT: begin
				scr_timeout = data;
				scr_idle    = '0;
			end
			CFG_BLANK_EN: scr_blank_en = data[0];
			default: ;
		endcase
	endtask

	task automatic push_item(logic [OP_W-1:0] op, level_t live, logic known);
		pending_items.push_back(item_t'{op, live, known});
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic level_t rand_level();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [TO_W-1:0] pick_timeout();
		case ($urandom_range(7))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'd2;
			default: return 16'($urandom_range(3, 12));
		endcase
	endfunction

	// mostly tick runs closed by a wake, blank or toggle; some noise items
	task automatic random_phase(int n);
		int cnt;
		int run;
		logic [OP_W-1:0] end_op;
		if ($urandom_range(3) == 0)
			cfg_write(CFG_UNUSED, 16'($urandom_range(65535)));
		cfg_write(CFG_TIMEOUT, pick_timeout());
		cfg_write(CFG_BLANK_EN, 16'($urandom_range(65535)));
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(9) == 0) begin
				push_item(2'($urandom_range(3)), rand_level(), 1'($urandom_range(1)));
				cnt++;
			end else begin
				run = $urandom_range(0, int'(scr_timeout) + 3);
				if (run > 16)
					run = 16;
				repeat (run) push_item(OP_TICK, rand_level(), 1'($urandom_range(1)));
				case ($urandom_range(2))
					0:       end_op = OP_WAKE;
					1:       end_op = OP_BLANK;
					default: end_op = OP_TOGGLE;
				endcase
				push_item(end_op, rand_level(), 1'($urandom_range(1)));
				cnt += run + 1;
			end
		end
		drain();
	endtask

	initial begin
		foreach (action_count[i])
			action_count[i] = 0;
		scr_mode        = MODE_ON;
		scr_idle        = '0;
		scr_saved_level = '0;
		scr_saved_known = 1'b0;
		scr_timeout     = '0;
		scr_blank_en    = 1'b1;
		send_idle_pct   = 13;
		recv_idle_pct   = 56;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timeout disabled: explicit blank, toggle both ways, wake with unknown level
		push_item(OP_TICK, 12'd4095, 1'b1);
		push_item(OP_WAKE, 12'd4095, 1'b1);
		push_item(OP_BLANK, 12'd4095, 1'b1);
		push_item(OP_BLANK, 12'd0, 1'b0);
		push_item(OP_TOGGLE, 12'd100, 1'b1);
		push_item(OP_TOGGLE, 12'd0, 1'b0);
		push_item(OP_WAKE, 12'd4095, 1'b1);
		drain();
		cfg_write(CFG_UNUSED, 16'hFFFF);
		push_item(OP_TICK, 12'd1, 1'b1);
		drain();

		// dim then off with the panel disabled
		cfg_write(CFG_TIMEOUT, 16'd3);
		cfg_write(CFG_BLANK_EN, 16'hFFFE);
		push_item(OP_TICK, 12'hAAA, 1'b1);
		push_item(OP_TICK, 12'h555, 1'b1);
		push_item(OP_TICK, 12'd7, 1'b0);
		push_item(OP_TICK, 12'd9, 1'b1);
		push_item(OP_BLANK, 12'd33, 1'b1);
		push_item(OP_TOGGLE, 12'd44, 1'b0);
		drain();
		cfg_write(CFG_BLANK_EN, 16'h0001);
		push_item(OP_TOGGLE, 12'h555, 1'b1);
		drain();
		// panel disabled while blanked: unblank still goes out
		cfg_write(CFG_BLANK_EN, 16'h0000);
		push_item(OP_WAKE, 12'd0, 1'b0);
		push_item(OP_BLANK, 12'hFFF, 1'b1);
		drain();
		cfg_write(CFG_BLANK_EN, 16'h0001);
		push_item(OP_BLANK, 12'd2, 1'b0);
		push_item(OP_WAKE, 12'd3, 1'b0);
		drain();

		// short timeouts go straight to off, old saved level kept
		cfg_write(CFG_TIMEOUT, 16'd1);
		push_item(OP_TICK, 12'd11, 1'b0);
		push_item(OP_TICK, 12'd12, 1'b0);
		push_item(OP_WAKE, 12'd13, 1'b0);
		drain();
		cfg_write(CFG_TIMEOUT, 16'd2);
		push_item(OP_TICK, 12'd21, 1'b1);
		push_item(OP_TICK, 12'd22, 1'b1);
		push_item(OP_TICK, 12'd23, 1'b1);
		push_item(OP_WAKE, 12'd24, 1'b1);
		drain();

		for (int k = 0; k < 4; k++)
			random_phase(18);

		send_idle_pct = 56;
		recv_idle_pct = 13;
		for (int k = 0; k < 2; k++)
			random_phase(18);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_armed    = 1'b1;
		random_phase(25);
		hold_armed    = 1'b0;
		for (int k = 0; k < 2; k++)
			random_phase(18);

		$display("tb: %0d items, %0d beats, %0d register writes, %0d mismatches",
			items_sent, beats_seen, cfg_writes, errors);
		$display("tb: status %0d, level %0d, hook %0d/%0d, panel %0d/%0d",
			action_count[ACT_STATUS], action_count[ACT_SET_LEVEL],
			action_count[ACT_BLANK_HOOK], action_count[ACT_UNBLANK_HOOK],
			action_count[ACT_PANEL_BLANK], action_count[ACT_PANEL_UNBLANK]);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
rtl/didbt_pkg.sv
rtl/didbt_front.sv
rtl/didbt_queue.sv
rtl/didbt_back.sv
rtl/display_idle_dim_blank_timer_top.sv
tb/sv/tb_display_idle_dim_blank_timer_top.sv
